// ===== sv/msp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and constants of the multi-channel servo pulse generator.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int unsigned ChannelsDefault = 8;

  localparam int unsigned FuncW    = 3;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned SlotW    = 8;
  localparam int unsigned CountW   = 12;
  localparam int unsigned PinW     = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 12;

  localparam int unsigned AngleMax     = 180;
  localparam int unsigned UsMin        = 500;
  localparam int unsigned UsMid        = 1500;
  localparam int unsigned UsMax        = 2500;
  localparam int unsigned SlotMinReset = 64;
  localparam int unsigned SlotMaxReset = 192;
  localparam int unsigned OffsetReset  = 62;
  localparam int unsigned FrameReset   = 2500;

  // Division by the angle span is a multiplication by a rounded-up reciprocal.
  // It is exact for every product of an angle and a slot range.
  localparam int unsigned RecipShift = 23;
  localparam int unsigned Recip      = ((2 ** RecipShift) + AngleMax - 1) / AngleMax;
  localparam int unsigned AngleW     = 8;
  localparam int unsigned AngleKW    = 24;
  localparam int unsigned ProdW      = AngleKW + SlotW;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_ANGLE  = 3'd1,
    FUNC_MIN    = 3'd2,
    FUNC_MAX    = 3'd3,
    FUNC_ATTACH = 3'd4,
    FUNC_DETACH = 3'd5,
    FUNC_READ   = 3'd6
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET = 1'b0,
    CFG_FRAME  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [ChanW-1:0]   channel;
    logic [ValueW-1:0]  value;
    logic [AngleKW-1:0] angle_k;
  } item_t;

  typedef struct packed {
    logic [PinW-1:0]  pin_levels;
    logic [SlotW-1:0] read_data;
    logic             frame_start;
  } result_t;

endpackage

// ===== sv/msp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_in_stage
// Input register. It also clamps the angle and scales it by the reciprocal
// of the angle span, so the execute stage needs only one multiplier.
// ----------------------------------------------------------------------------
module msp_in_stage
  import msp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [FuncW-1:0]  func_i,
  input  logic [ChanW-1:0]  channel_i,
  input  logic [ValueW-1:0] value_i,
  output logic              valid_o,
  input  logic              advance_i,
  output item_t             item_o
);

  logic              valid_q, valid_d;
  item_t             item_q;
  logic [AngleW-1:0] angle;
  logic              take;

  assign ready_o = !valid_q || advance_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    if (value_i > ValueW'(AngleMax)) begin
      angle = AngleW'(AngleMax);
    end else begin
      angle = value_i[AngleW-1:0];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.func    <= func_i;
      item_q.channel <= channel_i;
      item_q.value   <= value_i;
      item_q.angle_k <= AngleKW'(angle * AngleKW'(Recip));
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/msp_chan_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_chan_bank
// Channel settings, frame timer and configuration registers. Works out the
// result of the registered item and updates the state when it is executed.
// ----------------------------------------------------------------------------
module msp_chan_bank
  import msp_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_write_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                fire_i,
  input  item_t               item_i,
  output result_t             result_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [SlotW-1:0]    position_q [CHANNELS];
  logic [SlotW-1:0]    latched_q  [CHANNELS];
  logic [SlotW-1:0]    min_slot_q [CHANNELS];
  logic [SlotW-1:0]    max_slot_q [CHANNELS];
  logic [CHANNELS-1:0] attached_q;
  logic [CHANNELS-1:0] written_q;
  logic [CountW-1:0]   slot_cnt_q, slot_cnt_d;
  logic [SlotW-1:0]    offset_q;
  logic [CountW-1:0]   frame_q;

  func_e               func;
  logic [IdxW-1:0]     idx;
  logic                ok;
  logic                is_tick;
  logic                start;
  logic [CHANNELS-1:0] pins;
  logic [CountW:0]     cnt_next;
  logic [SlotW-1:0]    lo, hi, range, quot, new_pos, new_min, new_max;
  logic [ProdW-1:0]    prod;
  logic [ValueW-1:0]   us_min, us_max;

  assign func    = func_e'(item_i.func);
  assign idx     = IdxW'(item_i.channel);
  assign ok      = 32'(item_i.channel) < CHANNELS;
  assign is_tick = (func == FUNC_TICK);
  assign start   = (slot_cnt_q == '0);

  always_comb begin
    for (int n = 0; n < CHANNELS; n++) begin
      pins[n] = attached_q[n] && written_q[n] &&
                ({1'b0, slot_cnt_q} < ((CountW + 1)'(offset_q) +
                 (CountW + 1)'(start ? position_q[n] : latched_q[n])));
    end
  end

  always_comb begin
    cnt_next = (CountW + 1)'(slot_cnt_q) + 1'b1;
    if (cnt_next >= (CountW + 1)'(frame_q)) begin
      slot_cnt_d = '0;
    end else begin
      slot_cnt_d = cnt_next[CountW-1:0];
    end
  end

  always_comb begin
    lo      = min_slot_q[idx];
    hi      = max_slot_q[idx];
    range   = (hi >= lo) ? (hi - lo) : '0;
    prod    = ProdW'(item_i.angle_k) * ProdW'(range);
    quot    = prod[RecipShift +: SlotW];
    new_pos = quot + lo;
  end

  always_comb begin
    if (item_i.value < ValueW'(UsMin)) begin
      us_min = ValueW'(UsMin);
    end else if (item_i.value > ValueW'(UsMid)) begin
      us_min = ValueW'(UsMid);
    end else begin
      us_min = item_i.value;
    end
    if (item_i.value < ValueW'(UsMid)) begin
      us_max = ValueW'(UsMid);
    end else if (item_i.value > ValueW'(UsMax)) begin
      us_max = ValueW'(UsMax);
    end else begin
      us_max = item_i.value;
    end
    new_min = SlotW'((us_min - ValueW'(UsMin)) >> 3);
    new_max = SlotW'((us_max - ValueW'(UsMin)) >> 3);
  end

  for (genvar g = 0; g < PinW; g++) begin : g_pin
    if (g < CHANNELS) begin : g_used
      assign result_o.pin_levels[g] = is_tick && pins[g];
    end else begin : g_unused
      assign result_o.pin_levels[g] = 1'b0;
    end
  end

  assign result_o.read_data   = (ok && func == FUNC_READ) ? position_q[idx] : '0;
  assign result_o.frame_start = is_tick && start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= SlotW'(OffsetReset);
      frame_q  <= CountW'(FrameReset);
    end else if (cfg_write_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET: offset_q <= cfg_data_i[SlotW-1:0];
        CFG_FRAME:  frame_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < CHANNELS; n++) begin
        position_q[n] <= '0;
        latched_q[n]  <= '0;
        min_slot_q[n] <= SlotW'(SlotMinReset);
        max_slot_q[n] <= SlotW'(SlotMaxReset);
      end
      attached_q <= '0;
      written_q  <= '0;
      slot_cnt_q <= '0;
    end else if (fire_i) begin
      if (is_tick) begin
        if (start) begin
          for (int n = 0; n < CHANNELS; n++) begin
            latched_q[n] <= position_q[n];
          end
        end
        slot_cnt_q <= slot_cnt_d;
      end else if (ok) begin
        unique case (func)
          FUNC_ANGLE: begin
            position_q[idx] <= new_pos;
            written_q[idx]  <= 1'b1;
          end
          FUNC_MIN:    min_slot_q[idx] <= new_min;
          FUNC_MAX:    max_slot_q[idx] <= new_max;
          FUNC_ATTACH: attached_q[idx] <= 1'b1;
          FUNC_DETACH: attached_q[idx] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_cmd_holds_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !is_tick |=> $stable(slot_cnt_q))
    else $error("command moved the frame timer");

  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_tick && start && frame_q > CountW'(1) && !cfg_write_i
    |=> slot_cnt_q == CountW'(1))
    else $error("frame timer did not step from frame start");

  a_detach_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && ok && func == FUNC_DETACH |=> attached_q[$past(idx)] == 1'b0)
    else $error("detach left the channel attached");
`endif

endmodule

// ===== sv/multi_channel_servo_pulse_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_servo_pulse_generator_top
// Servo pulse generator: timeslot ticks drive the channel pins, commands edit
// the per-channel angle, pulse limits and attach state, or read back a position.
//
// Channel  Dir  Handshake               Payload
// s_axis   in   tvalid / tready         tuser func, tdata channel and value
// m_axis   out  tvalid / tready         tuser frame_start, tdata pins and read
// cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Every request gives one result; it passes the input register, then the output register.
// A request can be accepted in every cycle while the output does not stall; the rate is set by the single
// execute stage, whose longest path is one 24 by 8 bit multiplier.
// Reset restores all channel settings at once; no clearing pass is needed.
// A stalled output holds its result while the input register still takes one
// more request.
// ----------------------------------------------------------------------------
module multi_channel_servo_pulse_generator_top
  import msp_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // channel[2:0], value[18:3], zero
  input  logic [FuncW-1:0]    s_axis_tuser,   // func[2:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // pin_levels[7:0], read_data[15:8]
  output logic [0:0]          m_axis_tuser,   // frame_start[0]
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic    in_valid;
  logic    fire;
  item_t   item;
  result_t result;
  result_t out_q;
  logic    out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid && (!out_valid_q || m_axis_tready);

  msp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .func_i    (s_axis_tuser),
    .channel_i (s_axis_tdata[ChanW-1:0]),
    .value_i   (s_axis_tdata[ChanW +: ValueW]),
    .valid_o   (in_valid),
    .advance_i (fire),
    .item_o    (item)
  );

  msp_chan_bank #(
    .CHANNELS (CHANNELS)
  ) u_chan_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (item),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.read_data, out_q.pin_levels};
  assign m_axis_tuser  = out_q.frame_start;

`ifndef SYNTHESIS
  a_frame_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:8] == '0)
    else $error("frame start result carries read data");
`endif

endmodule
